@@ sv/nibble_blitter_with_clut_assert.svh @@
// ----------------------------------------------------------------------------
// nibble blitter assertion macros
// concurrent checks that compile away when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef NIBBLE_BLITTER_WITH_CLUT_ASSERT_SVH
`define NIBBLE_BLITTER_WITH_CLUT_ASSERT_SVH
`ifndef SYNTH
`define NBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("nbc check failed");
`define NBC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("nbc reset check failed");
`else
`define NBC_ASSERT(lbl, clk, rstn, prop)
`define NBC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

@@ sv/nbc_pkg.sv @@
// ----------------------------------------------------------------------------
// nbc_pkg
// shared constants, codes and types of the nibble blitter
// ----------------------------------------------------------------------------
package nbc_pkg;

  localparam int unsigned RomDepthDef = 262144;
  localparam int unsigned FrameSide   = 256;
  localparam int unsigned CoordW      = 8;
  localparam int unsigned FrameAw     = 2 * CoordW;
  localparam int unsigned SrcAddrW    = 19;

  typedef enum logic [1:0] {
    OP_REG_WR = 2'd0,
    OP_TBL_WR = 2'd1,
    OP_ROM_WR = 2'd2,
    OP_PIX_RD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_SRC_LO = 3'd0,
    REG_SRC_HI = 3'd1,
    REG_DST_X  = 3'd2,
    REG_DST_Y  = 3'd3,
    REG_SIZE_X = 3'd4,
    REG_SIZE_Y = 3'd5,
    REG_MODE   = 3'd6,
    REG_BANK   = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_BLIT_RD,
    ST_BLIT_WR
  } state_e;

  typedef struct packed {
    logic inc_x;
    logic inc_y;
    logic flip;
    logic disp;
  } mode_t;

endpackage

@@ sv/nibble_blitter_with_clut.sv @@
// ----------------------------------------------------------------------------
// nibble_blitter_with_clut
// register-driven blitter: rom nibbles through a colour table into a frame ram
// ----------------------------------------------------------------------------
// register, table and rom beats answer in the cycle after they are taken, a pixel
// read after ST_PIX_RD; size_y starts a blit: per pixel a rom read, a frame write
// one beat in flight at a time; the next is taken as the result is taken
// after reset a clearing pass zeroes all 65536 frame ram words, no beats
// are taken until it ends; a flip change costs nothing, it remaps read addresses
module nibble_blitter_with_clut #(
  parameter int unsigned RomDepth = nbc_pkg::RomDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_offset, data, table_index, rom_address, pixel_x, pixel_y
  input  logic [55:0] s_axis_tdata,
  // operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data, blit_pixels, source_address
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned RomAw = $clog2(RomDepth);

  nbc_pkg::state_e state_q, state_d;
  nbc_pkg::mode_t  mode_q;

  logic [2:0]  in_reg;
  logic [7:0]  in_data;
  logic [3:0]  in_tix;
  logic [17:0] in_raddr;
  logic [7:0]  in_px, in_py;
  nbc_pkg::op_e in_op;
  assign in_op    = nbc_pkg::op_e'(s_axis_tuser);
  assign in_reg   = s_axis_tdata[2:0];
  assign in_data  = s_axis_tdata[10:3];
  assign in_tix   = s_axis_tdata[14:11];
  assign in_raddr = s_axis_tdata[32:15];
  assign in_px    = s_axis_tdata[40:33];
  assign in_py    = s_axis_tdata[48:41];

  logic [15:0] src_q;
  logic [7:0]  dst_x_q, dst_y_q, size_x_q;
  logic [1:0]  rom_bank_q;
  logic        pal_bank_q;
  logic [7:0]  clut_q [16];

  logic [7:0]  span_x_q, span_y_q, start_x_q, x_q, y_q, col_q, row_q;
  logic [nbc_pkg::SrcAddrW-1:0] addr_q;
  logic        high_q;
  logic [16:0] pix_q;
  logic [15:0] clr_q;

  logic        out_valid_q;
  logic [7:0]  out_rd_q;
  logic [16:0] out_pix_q;

  logic        accept;
  logic        out_free;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == nbc_pkg::ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // memories
  logic              rom_we;
  logic [RomAw-1:0]  rom_raddr;
  logic [7:0]        rom_rdata;
  logic              fr_we;
  logic [15:0]       fr_waddr, fr_raddr;
  logic [7:0]        fr_wdata, fr_rdata;

  assign rom_we    = accept && (in_op == nbc_pkg::OP_ROM_WR)
                     && ({1'b0, in_raddr} < 19'(RomDepth));
  assign rom_raddr = (addr_q >= nbc_pkg::SrcAddrW'(RomDepth)) ? '0 : addr_q[RomAw-1:0];

  nbc_ram #(.Width(8), .Depth(RomDepth)) u_rom (
    .clk_i  (clk_i),
    .we_i   (rom_we),
    .waddr_i(in_raddr[RomAw-1:0]),
    .wdata_i(in_data),
    .raddr_i(rom_raddr),
    .rdata_o(rom_rdata)
  );

  // pixel reads invert the address when flip is on: physical = logical ^ all ones
  // blit writes use the coordinates as they are, so flip acts on the read side only
  logic [3:0] nib;
  logic [7:0] entry;
  logic       pix_we;
  logic [7:0] pix_val;
  assign nib   = high_q ? rom_rdata[7:4] : rom_rdata[3:0];
  assign entry = clut_q[nib];
  always_comb begin
    pix_we  = 1'b0;
    pix_val = {3'b000, pal_bank_q, nib};
    if (entry[7:4] != 4'd0) begin
      pix_we = (nib != 4'd0);
    end else begin
      pix_we  = (entry != 8'd0);
      pix_val = {3'b000, pal_bank_q, 4'd0} + entry;
    end
  end

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = {y_q, x_q};
    fr_wdata = pix_val;
    if (state_q == nbc_pkg::ST_CLEAR) begin
      fr_we    = 1'b1;
      fr_waddr = clr_q;
      fr_wdata = 8'd0;
    end else if (state_q == nbc_pkg::ST_BLIT_WR) begin
      fr_we = pix_we;
    end
  end
  assign fr_raddr = {in_py, in_px} ^ {16{mode_q.flip}};

  nbc_ram #(.Width(8), .Depth(nbc_pkg::FrameSide * nbc_pkg::FrameSide)) u_frame (
    .clk_i  (clk_i),
    .we_i   (fr_we),
    .waddr_i(fr_waddr),
    .wdata_i(fr_wdata),
    .raddr_i(fr_raddr),
    .rdata_o(fr_rdata)
  );

  logic last_col, last_pix;
  assign last_col = (col_q == span_x_q);
  assign last_pix = last_col && (row_q == span_y_q);

  logic [7:0] span_x_new, span_y_new;
  assign span_x_new = (mode_q.inc_x && size_x_q[7]) ? 8'hff - size_x_q : size_x_q;
  assign span_y_new = (mode_q.inc_y && in_data[7]) ? 8'hff - in_data : in_data;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nbc_pkg::ST_CLEAR:   if (clr_q == 16'hffff) state_d = nbc_pkg::ST_IDLE;
      nbc_pkg::ST_IDLE: begin
        if (accept && in_op == nbc_pkg::OP_PIX_RD) begin
          state_d = nbc_pkg::ST_PIX_RD;
        end else if (accept && in_op == nbc_pkg::OP_REG_WR
                     && nbc_pkg::reg_e'(in_reg) == nbc_pkg::REG_SIZE_Y) begin
          state_d = nbc_pkg::ST_BLIT_RD;
        end
      end
      nbc_pkg::ST_PIX_RD:  state_d = nbc_pkg::ST_IDLE;
      nbc_pkg::ST_BLIT_RD: state_d = nbc_pkg::ST_BLIT_WR;
      nbc_pkg::ST_BLIT_WR: state_d = last_pix ? nbc_pkg::ST_IDLE : nbc_pkg::ST_BLIT_RD;
      default:             state_d = nbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nbc_pkg::ST_CLEAR;
      clr_q       <= '0;
      mode_q      <= '0;
      src_q       <= '0;
      dst_x_q     <= '0;
      dst_y_q     <= '0;
      size_x_q    <= '0;
      rom_bank_q  <= '0;
      pal_bank_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) clut_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == nbc_pkg::ST_CLEAR) clr_q <= clr_q + 16'd1;
      if (m_axis_tready) out_valid_q <= 1'b0;
      if (accept) begin
        unique case (in_op)
          nbc_pkg::OP_REG_WR: begin
            unique case (nbc_pkg::reg_e'(in_reg))
              nbc_pkg::REG_SRC_LO: src_q[7:0]  <= in_data;
              nbc_pkg::REG_SRC_HI: src_q[15:8] <= in_data;
              nbc_pkg::REG_DST_X:  dst_x_q     <= in_data;
              nbc_pkg::REG_DST_Y:  dst_y_q     <= in_data;
              nbc_pkg::REG_SIZE_X: size_x_q    <= in_data;
              nbc_pkg::REG_SIZE_Y: ;
              nbc_pkg::REG_MODE: begin
                mode_q.inc_x <= in_data[0];
                mode_q.inc_y <= in_data[1];
                mode_q.flip  <= !in_data[2];
                mode_q.disp  <= !in_data[3];
              end
              nbc_pkg::REG_BANK: begin
                rom_bank_q <= in_data[7:6];
                pal_bank_q <= in_data[4];
              end
              default: ;
            endcase
          end
          nbc_pkg::OP_TBL_WR: clut_q[in_tix] <= in_data;
          default: ;
        endcase
        out_valid_q <= !((in_op == nbc_pkg::OP_PIX_RD)
                         || (in_op == nbc_pkg::OP_REG_WR
                             && nbc_pkg::reg_e'(in_reg) == nbc_pkg::REG_SIZE_Y));
      end
      if (state_q == nbc_pkg::ST_PIX_RD) out_valid_q <= 1'b1;
      if (state_q == nbc_pkg::ST_BLIT_WR && last_pix) out_valid_q <= 1'b1;
    end
  end

  // blit sequencer and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rd_q  <= '0;
      out_pix_q <= '0;
      span_x_q  <= span_x_new;
      span_y_q  <= span_y_new;
      start_x_q <= dst_x_q + size_x_q;
      x_q       <= dst_x_q + size_x_q;
      y_q       <= dst_y_q + in_data;
      col_q     <= '0;
      row_q     <= '0;
      high_q    <= 1'b0;
      pix_q     <= '0;
      addr_q    <= {1'b0, rom_bank_q, 16'd0} + {3'b000, src_q};
    end
    if (state_q == nbc_pkg::ST_PIX_RD) begin
      out_rd_q <= mode_q.disp ? fr_rdata : 8'd0;
    end
    if (state_q == nbc_pkg::ST_BLIT_WR) begin
      pix_q  <= pix_q + 17'd1;
      high_q <= !high_q;
      if (high_q) addr_q <= addr_q + 19'd1;
      if (last_col) begin
        col_q <= '0;
        row_q <= row_q + 8'd1;
        x_q   <= start_x_q;
        y_q   <= mode_q.inc_y ? y_q + 8'd1 : y_q - 8'd1;
      end else begin
        col_q <= col_q + 8'd1;
        x_q   <= mode_q.inc_x ? x_q + 8'd1 : x_q - 8'd1;
      end
      if (last_pix) out_pix_q <= pix_q + 17'd1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, src_q, out_pix_q, out_rd_q};

  // states that may write the frame ram
  logic fr_we_ok;
  assign fr_we_ok = (state_q == nbc_pkg::ST_CLEAR) || (state_q == nbc_pkg::ST_BLIT_WR);

`include "nibble_blitter_with_clut_assert.svh"

  `NBC_ASSERT(a_accept_idle, clk_i, rst_ni, accept |-> state_q == nbc_pkg::ST_IDLE)
  `NBC_ASSERT(a_frame_we_src, clk_i, rst_ni, fr_we |-> fr_we_ok)
  `NBC_ASSERT(a_busy_no_out, clk_i, rst_ni, (state_q == nbc_pkg::ST_BLIT_RD) |-> !out_valid_q)

endmodule

@@ sv/nbc_ram.sv @@
// ----------------------------------------------------------------------------
// nbc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module nbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
